// ===== rtl/core/chmoi_pkg.sv =====
`default_nettype none
package chmoi_pkg;
   localparam logic [2:0] FN_PUT    = 3'd0;
   localparam logic [2:0] FN_GET    = 3'd1;
   localparam logic [2:0] FN_REMOVE = 3'd2;
   localparam logic [2:0] FN_FIRST  = 3'd3;
   localparam logic [2:0] FN_NEXT   = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_CONTINUE  = 3'd3;
   localparam logic [2:0] ST_PARAM_ERR = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
endpackage
`default_nettype wire

// ===== rtl/core/chained_hash_map_ordered_iter.sv =====
`default_nettype none
// channel  ports                                   direction
// req      req_valid req_stall req_func/key/value_in   in
// rsp      rsp_valid rsp_stall rsp_status/key_out/value_out/entry_count  out
// A word reads its bucket head and walks the chain until the key is found or
// the chain ends; a put or remove then updates the slot and the order list.
// Iterate first and an unknown code skip the walk. The shared slot read port
// sets the pace. After reset a clearing pass empties the bucket heads; no
// word is taken meanwhile. A result waits in the output register while
// rsp_stall is high, and req_stall stays high until it has left.
module chained_hash_map_ordered_iter #(
   parameter int BUCKETS = 32,
   parameter int ENTRIES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_value_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_key_out,
   output logic [31:0]      rsp_value_out,
   output logic [6:0]       rsp_entry_count
);
   import chmoi_pkg::*;
   localparam int AW = $clog2(ENTRIES);
   localparam int LW = $clog2(ENTRIES + 1);
   localparam int BW = $clog2(BUCKETS);
   localparam logic [LW-1:0] NIL = LW'(ENTRIES);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_HEAD, S_HEADW, S_WALK, S_WALKW, S_DECIDE,
      S_PUT0, S_PUT1, S_PUT2, S_PUT3,
      S_REM0, S_REM1, S_REM2, S_REM3,
      S_IT0, S_IT1, S_IT2, S_NX0, S_NX1, S_NX2, S_NX3, S_OUT
   } state_type;

   logic [LW-1:0] head_mem [BUCKETS];
   logic [31:0]   key_mem [ENTRIES];
   logic [31:0]   val_mem [ENTRIES];
   logic [LW-1:0] cnext_mem [ENTRIES];
   logic [AW-1:0] onext_mem [ENTRIES];
   logic [AW-1:0] oprev_mem [ENTRIES];

   state_type     state_ff;
   logic [BW-1:0] clr_ff;
   logic [2:0]    func_ff;
   logic [31:0]   key_ff, val_ff;
   logic [LW-1:0] cur_ff, prev_ff, first_ff, tmp_ff;
   logic [AW-1:0] nx_ff, pv_ff;
   logic [LW:0]   guard_ff;
   logic [ENTRIES-1:0] free_ff;
   logic [6:0]    count_ff;
   logic [31:0]   rkey_ff, rval_ff, rdkey_ff;
   logic [LW-1:0] rdcn_ff;
   logic [AW-1:0] rdon_ff, rdop_ff;
   logic [LW-1:0] rdhead_ff;
   logic [2:0]    st_ff;
   logic [31:0]   ko_ff, vo_ff;
   logic          ov_ff;
   logic [LW-1:0] low_free;
   logic [BW-1:0] bkt;

   assign bkt = BW'(key_ff % BUCKETS);

   always_comb begin
      low_free = NIL;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (free_ff[i]) low_free = LW'(i);
      end
   end

   assign req_stall = (state_ff != S_IDLE) || ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_status = st_ff;
   assign rsp_key_out = ko_ff;
   assign rsp_value_out = vo_ff;
   assign rsp_entry_count = count_ff;

   // slot memory reads, registered
   logic [AW-1:0] raddr;
   always_comb begin
      raddr = cur_ff[AW-1:0];
      if (state_ff == S_PUT0 || state_ff == S_PUT1 || state_ff == S_IT0 ||
          state_ff == S_IT1) raddr = first_ff[AW-1:0];
      if (state_ff == S_NX1 || state_ff == S_NX2 || state_ff == S_REM1) raddr = nx_ff;
      if (state_ff == S_REM2) raddr = pv_ff;
   end
   always_ff @(posedge clock) begin
      rdkey_ff <= key_mem[raddr];
      rdcn_ff <= cnext_mem[raddr];
      rdon_ff <= onext_mem[raddr];
      rdop_ff <= oprev_mem[raddr];
      rdhead_ff <= head_mem[bkt];
      rkey_ff <= key_mem[raddr];
      rval_ff <= val_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         ov_ff <= 1'b0;
         first_ff <= NIL;
         free_ff <= '1;
         count_ff <= '0;
      end else begin
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               head_mem[clr_ff] <= NIL;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BW'(BUCKETS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  func_ff <= req_func;
                  key_ff <= req_key;
                  val_ff <= req_value_in;
                  ko_ff <= '0;
                  vo_ff <= '0;
                  st_ff <= ST_PARAM_ERR;
                  if (req_func == FN_FIRST) state_ff <= S_IT0;
                  else if (req_func > FN_NEXT) state_ff <= S_OUT;
                  else state_ff <= S_HEAD;
               end
            end
            S_HEAD: state_ff <= S_HEADW;
            S_HEADW: begin
               cur_ff <= rdhead_ff;
               prev_ff <= NIL;
               guard_ff <= '0;
               state_ff <= S_WALK;
            end
            S_WALK: begin
               if (cur_ff >= NIL || guard_ff > (LW+1)'(ENTRIES)) begin
                  cur_ff <= NIL;
                  state_ff <= S_DECIDE;
               end else state_ff <= S_WALKW;
            end
            S_WALKW: begin
               if (rdkey_ff == key_ff) state_ff <= S_DECIDE;
               else begin
                  prev_ff <= cur_ff;
                  cur_ff <= rdcn_ff;
                  guard_ff <= guard_ff + 1'b1;
                  state_ff <= S_WALK;
               end
            end
            S_DECIDE: begin
               state_ff <= S_OUT;
               unique case (func_ff)
                  FN_PUT: begin
                     if (cur_ff != NIL) st_ff <= ST_DUPLICATE;
                     else if (low_free == NIL || count_ff >= 7'(ENTRIES)) st_ff <= ST_FULL;
                     else begin
                        tmp_ff <= low_free;
                        state_ff <= S_PUT0;
                     end
                  end
                  FN_GET: begin
                     if (cur_ff == NIL) st_ff <= ST_NOT_FOUND;
                     else begin
                        st_ff <= ST_OK;
                        vo_ff <= rval_ff;
                     end
                  end
                  FN_REMOVE: begin
                     if (cur_ff == NIL) st_ff <= ST_NOT_FOUND;
                     else begin
                        vo_ff <= rval_ff;
                        nx_ff <= rdon_ff;
                        pv_ff <= rdop_ff;
                        if (prev_ff == NIL) head_mem[bkt] <= rdcn_ff;
                        else cnext_mem[prev_ff[AW-1:0]] <= rdcn_ff;
                        state_ff <= S_REM0;
                     end
                  end
                  default: begin
                     if (cur_ff != NIL && first_ff != NIL) begin
                        nx_ff <= rdon_ff;
                        state_ff <= S_NX0;
                     end
                  end
               endcase
            end
            S_PUT0: begin
               free_ff[tmp_ff[AW-1:0]] <= 1'b0;
               key_mem[tmp_ff[AW-1:0]] <= key_ff;
               val_mem[tmp_ff[AW-1:0]] <= val_ff;
               cnext_mem[tmp_ff[AW-1:0]] <= rdhead_ff;
               head_mem[bkt] <= tmp_ff;
               count_ff <= count_ff + 1'b1;
               st_ff <= ST_OK;
               if (first_ff == NIL) begin
                  first_ff <= tmp_ff;
                  onext_mem[tmp_ff[AW-1:0]] <= tmp_ff[AW-1:0];
                  oprev_mem[tmp_ff[AW-1:0]] <= tmp_ff[AW-1:0];
                  state_ff <= S_OUT;
               end else state_ff <= S_PUT1;
            end
            S_PUT1: state_ff <= S_PUT2;
            S_PUT2: begin
               onext_mem[rdop_ff] <= tmp_ff[AW-1:0];
               oprev_mem[first_ff[AW-1:0]] <= tmp_ff[AW-1:0];
               onext_mem[tmp_ff[AW-1:0]] <= first_ff[AW-1:0];
               oprev_mem[tmp_ff[AW-1:0]] <= rdop_ff;
               state_ff <= S_PUT3;
            end
            S_PUT3: state_ff <= S_OUT;
            S_REM0: begin
               free_ff[cur_ff[AW-1:0]] <= 1'b1;
               if (count_ff != 0) count_ff <= count_ff - 1'b1;
               st_ff <= ST_OK;
               if (LW'(nx_ff) == cur_ff) begin
                  first_ff <= NIL;
                  state_ff <= S_OUT;
               end else begin
                  if (first_ff == cur_ff) first_ff <= LW'(nx_ff);
                  state_ff <= S_REM1;
               end
            end
            S_REM1: begin
               onext_mem[pv_ff] <= nx_ff;
               oprev_mem[nx_ff] <= pv_ff;
               state_ff <= S_REM3;
            end
            S_REM2: state_ff <= S_OUT;
            S_REM3: state_ff <= S_OUT;
            S_IT0: begin
               if (first_ff == NIL) begin
                  st_ff <= ST_NOT_FOUND;
                  state_ff <= S_OUT;
               end else state_ff <= S_IT1;
            end
            S_IT1: state_ff <= S_IT2;
            S_IT2: begin
               ko_ff <= rkey_ff;
               vo_ff <= rval_ff;
               st_ff <= (LW'(rdon_ff) == first_ff) ? ST_OK : ST_CONTINUE;
               state_ff <= S_OUT;
            end
            S_NX0: begin
               if (LW'(nx_ff) == first_ff) state_ff <= S_OUT;
               else state_ff <= S_NX1;
            end
            S_NX1: state_ff <= S_NX2;
            S_NX2: state_ff <= S_NX3;
            S_NX3: begin
               ko_ff <= rkey_ff;
               vo_ff <= rval_ff;
               st_ff <= (LW'(rdon_ff) == first_ff) ? ST_OK : ST_CONTINUE;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               ov_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/chmoi_checker.sv =====
`default_nettype none
module chmoi_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_status,
   input wire logic [6:0] rsp_entry_count
);
   import chmoi_pkg::*;
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped while stalled");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("word taken while result pending");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL)
      else $error("bad status");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= 7'd64)
      else $error("count overflow");
endmodule
bind chained_hash_map_ordered_iter chmoi_checker u_chk (.*);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import chmoi_pkg::*;

   localparam int NB = 32;
   localparam int NE = 64;
   localparam int NIL = NE;
   localparam int WATCHDOG = 20000;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] key;
      logic [31:0] value;
   } op_word_t;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] key;
      logic [31:0] value;
      logic [6:0]  count;
   } map_reply_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_func = 0;
   logic [31:0] req_key = 0;
   logic [31:0] req_value_in = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_key_out;
   logic [31:0] rsp_value_out;
   logic [6:0]  rsp_entry_count;

   chained_hash_map_ordered_iter dut (.*);

   always #2 clock = ~clock;

   // shadow of the map
   int          m_head [NB];
   logic [31:0] m_key [NE];
   logic [31:0] m_val [NE];
   int          m_chain [NE];
   int          m_onext [NE];
   int          m_oprev [NE];
   int          m_first;
   bit          m_free [NE];
   int          m_used;
   logic [31:0] live_keys [$];

   op_word_t   pending_ops [$];
   map_reply_t expected_replies [$];
   bit         stimulus_done = 0;
   bit         quiet = 0;
   int         errors = 0;
   int         idle_cycles = 0;
   int         cycle = 0;

   function automatic int find_slot(logic [31:0] k, output int prev);
      int cur;
      int guard;
      prev = NIL;
      cur = m_head[k % NB];
      guard = 0;
      while (cur < NE && guard <= NE) begin
         if (m_key[cur] == k) break;
         prev = cur;
         cur = m_chain[cur];
         guard++;
      end
      if (cur >= NE || guard > NE) cur = NIL;
      return cur;
   endfunction

   function automatic map_reply_t apply_op(op_word_t w);
      map_reply_t r;
      int s, prev, b, nx, tail;
      r = '0;
      r.status = ST_PARAM_ERR;
      case (w.func)
         FN_PUT: begin
            if (find_slot(w.key, prev) != NIL) begin
               r.status = ST_DUPLICATE;
            end else begin
               s = NIL;
               for (int i = NE - 1; i >= 0; i--) if (m_free[i]) s = i;
               if (s == NIL || m_used >= NE) begin
                  r.status = ST_FULL;
               end else begin
                  m_free[s] = 0;
                  b = w.key % NB;
                  m_key[s] = w.key;
                  m_val[s] = w.value;
                  m_chain[s] = m_head[b];
                  m_head[b] = s;
                  if (m_first >= NE) begin
                     m_first = s;
                     m_onext[s] = s;
                     m_oprev[s] = s;
                  end else begin
                     tail = m_oprev[m_first];
                     m_onext[tail] = s;
                     m_oprev[m_first] = s;
                     m_onext[s] = m_first;
                     m_oprev[s] = tail;
                  end
                  m_used++;
                  live_keys.push_back(w.key);
                  r.status = ST_OK;
               end
            end
         end
         FN_GET: begin
            s = find_slot(w.key, prev);
            if (s == NIL) r.status = ST_NOT_FOUND;
            else begin
               r.status = ST_OK;
               r.value = m_val[s];
            end
         end
         FN_REMOVE: begin
            s = find_slot(w.key, prev);
            if (s == NIL) r.status = ST_NOT_FOUND;
            else begin
               if (prev == NIL) m_head[w.key % NB] = m_chain[s];
               else m_chain[prev] = m_chain[s];
               r.value = m_val[s];
               nx = m_onext[s];
               if (nx == s) m_first = NIL;
               else begin
                  if (m_first == s) m_first = nx;
                  m_onext[m_oprev[s]] = nx;
                  m_oprev[nx] = m_oprev[s];
               end
               m_free[s] = 1;
               if (m_used > 0) m_used--;
               foreach (live_keys[i]) if (live_keys[i] == w.key) begin
                  live_keys.delete(i);
                  break;
               end
               r.status = ST_OK;
            end
         end
         FN_FIRST: begin
            if (m_first >= NE) r.status = ST_NOT_FOUND;
            else begin
               r.key = m_key[m_first];
               r.value = m_val[m_first];
               r.status = (m_onext[m_first] == m_first) ? ST_OK : ST_CONTINUE;
            end
         end
         FN_NEXT: begin
            s = find_slot(w.key, prev);
            if (s != NIL && m_first < NE) begin
               nx = m_onext[s];
               if (nx < NE && nx != m_first) begin
                  r.key = m_key[nx];
                  r.value = m_val[nx];
                  r.status = (m_onext[nx] == m_first) ? ST_OK : ST_CONTINUE;
               end
            end
         end
         default: ;
      endcase
      r.count = m_used[6:0];
      return r;
   endfunction

   function automatic int idle_pct();
      return quiet ? 0 : 28;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) expected_replies.push_back(apply_op({req_func, req_key, req_value_in}));
         if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct()) begin
            op_word_t w;
            w = pending_ops.pop_front();
            req_valid <= 1;
            req_func <= w.func;
            req_key <= w.key;
            req_value_in <= w.value;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle++;
      if (!reset) begin
         rsp_stall <= ($urandom_range(99) < idle_pct());
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("reply with nothing expected");
               errors++;
            end else begin
               map_reply_t e;
               e = expected_replies.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status exp %0d got %0d", e.status, rsp_status); errors++;
               end
               if (rsp_key_out !== e.key) begin
                  $error("key_out exp %h got %h", e.key, rsp_key_out); errors++;
               end
               if (rsp_value_out !== e.value) begin
                  $error("value_out exp %h got %h", e.value, rsp_value_out); errors++;
               end
               if (rsp_entry_count !== e.count) begin
                  $error("entry_count exp %0d got %0d", e.count, rsp_entry_count);
                  errors++;
               end
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("chained_hash_map_ordered_iter test failed");
            $finish;
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(3))
         0: return 32'hFFFF_FFFF - $urandom_range(3);
         1: return $urandom_range(300);
         default: return $urandom;
      endcase
   endfunction

   // pick a key: a mostly live key, otherwise a random one, sometimes bucket-colliding
   function automatic logic [31:0] pick_key(int n_live_hint);
      if (live_keys.size() > 0 && $urandom_range(99) < 60)
         return live_keys[$urandom_range(live_keys.size() - 1)];
      if ($urandom_range(1)) return ($urandom_range(7) * NB) + $urandom_range(3);
      return rand_word();
   endfunction

   task automatic push_op(logic [2:0] f, logic [31:0] k, logic [31:0] v);
      pending_ops.push_back('{func: f, key: k, value: v});
   endtask

   task automatic wait_drain();
      while (pending_ops.size() > 0 || req_valid || expected_replies.size() > 0)
         @(negedge clock);
   endtask

   initial begin
      logic [31:0] k;
      int f;
      for (int i = 0; i < NB; i++) m_head[i] = NIL;
      for (int i = 0; i < NE; i++) begin
         m_free[i] = 1;
         m_chain[i] = 0;
         m_onext[i] = 0;
         m_oprev[i] = 0;
         m_key[i] = 0;
         m_val[i] = 0;
      end
      m_first = NIL;
      m_used = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed
      push_op(FN_FIRST, 0, 0);
      push_op(FN_GET, 5, 0);
      push_op(FN_REMOVE, 5, 0);
      push_op(FN_NEXT, 5, 0);
      push_op(FN_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_op(FN_FIRST, 0, 0);
      push_op(FN_NEXT, 32'hFFFF_FFFF, 0);
      push_op(FN_PUT, 32'hFFFF_FFFF, 1);
      push_op(FN_PUT, 0, 0);
      push_op(FN_PUT, 32, 32'hA5A5_5A5A);
      push_op(FN_PUT, 64, 32'h5A5A_A5A5);
      push_op(FN_GET, 32, 0);
      push_op(FN_GET, 96, 0);
      push_op(FN_FIRST, 0, 0);
      push_op(FN_NEXT, 32'hFFFF_FFFF, 0);
      push_op(FN_NEXT, 32, 0);
      push_op(FN_NEXT, 64, 0);
      push_op(FN_REMOVE, 32, 0);
      push_op(FN_REMOVE, 32'hFFFF_FFFF, 0);
      push_op(FN_FIRST, 0, 0);
      push_op(3'd5, 1, 1);
      push_op(3'd6, 2, 2);
      push_op(3'd7, 3, 3);
      push_op(FN_REMOVE, 0, 0);
      push_op(FN_REMOVE, 64, 0);
      wait_drain();

      // fill to full, probe, then random
      for (int i = 0; i < NE + 2; i++) push_op(FN_PUT, i * 7 + 1, $urandom);
      push_op(FN_FIRST, 0, 0);
      push_op(FN_NEXT, (NE - 1) * 7 + 1, 0);
      push_op(FN_PUT, 32'h1234_5678, 0);
      wait_drain();

      for (int n = 0; n < 2000; n++) begin
         if (n % 100 == 0) begin
            wait_drain();
            quiet = (n >= 800 && n < 1100);
         end
         f = $urandom_range(99);
         if (live_keys.size() > 0 && $urandom_range(99) < 70)
            k = live_keys[$urandom_range(live_keys.size() - 1)];
         else k = pick_key(0);
         if (f < 35) push_op(FN_PUT, k, rand_word());
         else if (f < 50) push_op(FN_GET, k, rand_word());
         else if (f < 70) push_op(FN_REMOVE, k, rand_word());
         else if (f < 75) push_op(FN_FIRST, k, rand_word());
         else if (f < 97) push_op(FN_NEXT, k, rand_word());
         else push_op(3'($urandom_range(5, 7)), k, rand_word());
      end
      stimulus_done = 1;
      wait_drain();
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_replies.size() == 0)
         $display("chained_hash_map_ordered_iter test passed");
      else $display("chained_hash_map_ordered_iter test failed");
      $finish;
   end
endmodule
